// ----- hw/rtl/bdq_pkg.sv -----
// bounded deque package: sizes, operation and status codes, item structs
// depends on nothing; used by bounded_deque_top and bdq_ctrl
`timescale 1ns / 1ps

package bdq_pkg;

    // ring size and stored word width
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 5;
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W     = CNT_W + 1;
    localparam int OUT_W     = 32;
    localparam int OUT_CNT_W = 5;

    // operation codes
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_REAR   = 3'd3;
    localparam logic [2:0] MODE_QUERY      = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [OUT_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] front_word;
        logic signed [OUT_W-1:0] rear_word;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic                    is_full;
        logic                    is_empty;
        logic [1:0]              status;
    } t_out_item;

    // control group from the sequencer to the output stage
    typedef struct packed {
        logic       load;
        logic [1:0] status;
        t_cnt       count;
        logic       full;
        logic       empty;
    } t_resp;

endpackage

// ----- hw/rtl/bounded_deque_top.sv -----
// bounded deque top level: sequencer, entry ram and result register
// depends on bdq_pkg, bdq_ram and bdq_ctrl
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words held in a 16-entry ring
// in a synchronous ram. Each input item carries an operation (push front,
// push rear, pop front, pop rear, query) and a word; each accepted item
// yields exactly one result item with the front and rear words after the
// operation (all ones when empty), the count, full and empty flags and a
// status (ok, push rejected because full, pop rejected because empty).
// A rejected operation leaves the queue unchanged. An accepted item goes
// through an update step (head pointer, count and a pushed word written),
// a ram read step for the front and rear entries and a load step into the
// result register; o_in_stall is high during the read and load steps, so
// no new item is taken until the current one is loaded. A finished result
// waits in its output register while the next item is accepted and worked
// on; only the final load step waits on a stalled output. The capacity
// limit (reset 16; 0 or above 16 acts as 16) is written through the config
// port; the user must do so while idle, as the block does not enforce it.
// If it is lowered below the current count the entries are kept and the
// queue reads full. No clearing pass: unwritten entries never reach a result.

module bounded_deque_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  bdq_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output bdq_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bdq_pkg::CFG_W-1:0]  i_cfg_data
);

    logic               ram_we;
    bdq_pkg::t_idx      ram_waddr;
    bdq_pkg::t_word     ram_wdata;
    logic               ram_re;
    bdq_pkg::t_idx      ram_raddr_front;
    bdq_pkg::t_idx      ram_raddr_rear;
    bdq_pkg::t_word     ram_front;
    bdq_pkg::t_word     ram_rear;
    bdq_pkg::t_resp     resp;

    logic               r_out_valid;
    bdq_pkg::t_out_item r_out_item;
    logic               out_busy;

    // the limit register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // a result still held and stalled blocks the next load
    assign out_busy = r_out_valid && i_out_stall;

    bdq_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_item         (i_in_item),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_out_busy        (out_busy),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_re          (ram_re),
        .o_ram_raddr_front (ram_raddr_front),
        .o_ram_raddr_rear  (ram_raddr_rear),
        .o_resp            (resp)
    );

    // entry store: write in the update cycle, read in the cycle after it,
    // so a read never overlaps the write of the same item
    bdq_ram #(
        .DEPTH (bdq_pkg::DEPTH),
        .WIDTH (bdq_pkg::WORD_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_front),
        .i_raddr_b (ram_raddr_rear),
        .o_rdata_a (ram_front),
        .o_rdata_b (ram_rear)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp.load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp.load) begin
            if (resp.empty) begin
                r_out_item.front_word <= '1;
                r_out_item.rear_word  <= '1;
            end else begin
                // stored words are unsigned bits, zero extended to the port
                r_out_item.front_word <= bdq_pkg::OUT_W'(ram_front);
                r_out_item.rear_word  <= bdq_pkg::OUT_W'(ram_rear);
            end
            r_out_item.entry_count <= bdq_pkg::OUT_CNT_W'(resp.count);
            r_out_item.is_full     <= resp.full;
            r_out_item.is_empty    <= resp.empty;
            r_out_item.status      <= resp.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hw/rtl/bdq_ram.sv -----
// generic synchronous ram: one write port, two registered read ports
// depends on nothing
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                         o_rdata_a,
    output logic [WIDTH-1:0]                         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
// deque sequencer: head pointer, occupancy, limit register and item sequencing
// depends on bdq_pkg; drives the ports of bdq_ram
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  bdq_pkg::t_in_item          i_in_item,
    input  logic                       i_cfg_valid,
    input  logic [bdq_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_out_busy,
    output logic                       o_ram_we,
    output bdq_pkg::t_idx              o_ram_waddr,
    output bdq_pkg::t_word             o_ram_wdata,
    output logic                       o_ram_re,
    output bdq_pkg::t_idx              o_ram_raddr_front,
    output bdq_pkg::t_idx              o_ram_raddr_rear,
    output bdq_pkg::t_resp             o_resp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]                r_state, n_state;
    bdq_pkg::t_idx             r_head,  n_head;
    bdq_pkg::t_cnt             r_occ,   n_occ;
    logic [1:0]                r_status, n_status;
    logic [bdq_pkg::CFG_W-1:0] r_cap;

    logic                      in_accept;
    logic [bdq_pkg::CMP_W-1:0] limit;
    logic                      full;
    logic                      load_now;

    // pos + n modulo DEPTH, pos below DEPTH and n at most DEPTH
    function automatic bdq_pkg::t_idx ring_add(bdq_pkg::t_idx pos, bdq_pkg::t_cnt n);
        logic [bdq_pkg::SUM_W-1:0] sum;
        sum = bdq_pkg::SUM_W'(pos) + bdq_pkg::SUM_W'(n);
        if (sum >= bdq_pkg::SUM_W'(bdq_pkg::DEPTH)) begin
            sum = sum - bdq_pkg::SUM_W'(bdq_pkg::DEPTH);
        end
        return bdq_pkg::IDX_W'(sum);
    endfunction

    function automatic bdq_pkg::t_idx ring_dec(bdq_pkg::t_idx pos);
        bdq_pkg::t_idx res;
        if (pos == '0) begin
            res = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);
        end else begin
            res = pos - 1'b1;
        end
        return res;
    endfunction

    function automatic bdq_pkg::t_idx ring_inc(bdq_pkg::t_idx pos);
        bdq_pkg::t_idx res;
        if (pos == bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1)) begin
            res = '0;
        end else begin
            res = pos + 1'b1;
        end
        return res;
    endfunction

    assign in_accept  = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    // zero or out-of-range limit acts as the full ring
    always_comb begin
        if (r_cap == '0 || bdq_pkg::CMP_W'(r_cap) > bdq_pkg::CMP_W'(bdq_pkg::DEPTH)) begin
            limit = bdq_pkg::CMP_W'(bdq_pkg::DEPTH);
        end else begin
            limit = bdq_pkg::CMP_W'(r_cap);
        end
    end

    assign full = bdq_pkg::CMP_W'(r_occ) >= limit;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_occ       = r_occ;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = ring_add(r_head, r_occ);
        o_ram_wdata = bdq_pkg::WORD_BITS'($unsigned(i_in_item.value));
        o_ram_re    = 1'b0;
        load_now    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_status = bdq_pkg::STATUS_OK;
                    n_state  = S_READ;
                    unique case (i_in_item.mode)
                        bdq_pkg::MODE_PUSH_FRONT: begin
                            if (full) begin
                                n_status = bdq_pkg::STATUS_FULL;
                            end else begin
                                n_head      = ring_dec(r_head);
                                o_ram_we    = 1'b1;
                                o_ram_waddr = ring_dec(r_head);
                                n_occ       = r_occ + 1'b1;
                            end
                        end
                        bdq_pkg::MODE_PUSH_REAR: begin
                            if (full) begin
                                n_status = bdq_pkg::STATUS_FULL;
                            end else begin
                                o_ram_we = 1'b1;
                                n_occ    = r_occ + 1'b1;
                            end
                        end
                        bdq_pkg::MODE_POP_FRONT: begin
                            if (r_occ == '0) begin
                                n_status = bdq_pkg::STATUS_EMPTY;
                            end else begin
                                n_head = ring_inc(r_head);
                                n_occ  = r_occ - 1'b1;
                            end
                        end
                        bdq_pkg::MODE_POP_REAR: begin
                            if (r_occ == '0) begin
                                n_status = bdq_pkg::STATUS_EMPTY;
                            end else begin
                                n_occ = r_occ - 1'b1;
                            end
                        end
                        default: begin
                            // query and unused codes leave the state alone
                        end
                    endcase
                end
            end
            S_READ: begin
                o_ram_re = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (!i_out_busy) begin
                    load_now = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // front and rear of the updated ring; rear address only matters when not empty
    assign o_ram_raddr_front = r_head;
    assign o_ram_raddr_rear  = ring_add(r_head, r_occ - 1'b1);

    assign o_resp = '{load: load_now, status: r_status, count: r_occ, full: full,
                      empty: (r_occ == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_status <= bdq_pkg::STATUS_OK;
            r_cap    <= bdq_pkg::CFG_W'(16);
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_status <= n_status;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("occupancy above ring depth");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_READ))
        else $error("accepted item not followed by ram read");

    a_write_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (in_accept && !full &&
            (i_in_item.mode == bdq_pkg::MODE_PUSH_FRONT ||
             i_in_item.mode == bdq_pkg::MODE_PUSH_REAR)))
        else $error("ram written outside an accepted push");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && full && i_in_item.mode == bdq_pkg::MODE_PUSH_REAR) |=>
            (r_occ == $past(r_occ) && r_status == bdq_pkg::STATUS_FULL))
        else $error("rejected push changed occupancy");

    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp.load |-> (r_state == S_LOAD && !i_out_busy))
        else $error("result loaded outside load step");

endmodule
